[hw/rtl/bhpq_pkg.sv]
`default_nettype none

package bhpq_pkg;

   localparam int DEF_CAPACITY  = 1024;
   localparam int VALUE_W       = 32;
   localparam int ENTRY_COUNT_W = 11;
   localparam int STATUS_W      = 2;

   // stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * VALUE_W - ENTRY_COUNT_W;

   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0]        status_type;

   // request kinds
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // result status codes
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/bhpq_rank.sv]
`default_nettype none

// shared ordering compare: a ranks above b under the selected order
module bhpq_rank import bhpq_pkg::*; (
   input  wire value_type a_val,
   input  wire value_type b_val,
   input  wire logic      order_max,
   output logic           above
);

   always_comb begin
      if (order_max) begin
         above = (a_val > b_val);
      end else begin
         above = (a_val < b_val);
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bhpq_store.sv]
`default_nettype none

// heap entry memory, one write port and two registered read ports
module bhpq_store import bhpq_pkg::*; #(
   parameter int DEPTH  = DEF_CAPACITY,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire value_type         wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output value_type              rd_data_a,
   output value_type              rd_data_b
);

   value_type mem [DEPTH];
   value_type rd_a_ff;
   value_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[hw/rtl/binary_heap_priority_queue_top.sv]
`default_nettype none

// binary heap priority queue of signed 32-bit values
//
// req channel: one transfer is one request; req_tuser is the kind (0 insert,
// 1 pop) and req_tdata the value to insert. rsp channel: exactly one result
// transfer per request with the popped value, the new top and the count in
// rsp_tdata and the status code in rsp_tuser (0 done, 1 pop on empty heap,
// 2 insert on full heap). rejected requests leave the heap untouched.
// csr_we/csr_wdata write the order bit (0 smallest on top, 1 largest on top);
// write it only while the block is idle, the held entries are not reordered.
//
// each request is worked by a small sequencer around one memory and one
// shared compare unit: a sift works each heap level as a memory read,
// then a compare and write; req_tready is high only between requests.
// the result sits in an output register; when the receiver stalls, the next
// request is still taken and worked, and waits at its end for the register.
// reset empties the heap and clears the order bit; no memory clearing pass
module binary_heap_priority_queue_top import bhpq_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic                  req_tuser,  // [0] mode
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [31:0] popped_value, [63:32] top_value,
                                                  // [74:64] entry_count, [79:75] zero
   output logic [STATUS_W-1:0]        rsp_tuser,  // [1:0] status
   // configuration
   input  wire logic                  csr_we,
   input  wire logic                  csr_wdata   // order_select
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW1   = CNT_W + 1;  // holds child indices up to twice the capacity

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_UP_RD   = 4'd1;  // read parent or finish at the root
   localparam logic [3:0] S_UP_CMP  = 4'd2;  // compare with parent, move parent down
   localparam logic [3:0] S_POP_LD  = 4'd3;  // root and last entry arrive
   localparam logic [3:0] S_DN_SEL  = 4'd4;  // pick the better child
   localparam logic [3:0] S_DN_CMP  = 4'd5;  // compare child with moving entry
   localparam logic [3:0] S_PUT     = 4'd6;  // write moving entry at its slot
   localparam logic [3:0] S_TOP_RD  = 4'd7;
   localparam logic [3:0] S_TOP_CAP = 4'd8;  // load the result register

   logic [3:0]       state_ff, state_in;
   logic             order_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;         // slot of the moving entry
   value_type        cur_ff, cur_in;         // moving entry, not yet written
   logic [IDX_W-1:0] lidx_ff, lidx_in;       // left child being looked at
   logic             has_right_ff, has_right_in;
   logic [IDX_W-1:0] child_ff, child_in;
   value_type        child_val_ff, child_val_in;
   value_type        popped_ff, popped_in;
   status_type       status_ff, status_in;

   // result register
   logic                     rsp_valid_ff;
   value_type                rsp_popped_ff;
   value_type                rsp_top_ff;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff;
   status_type               rsp_status_ff;

   // memory port
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   value_type        mem_wdata;
   logic [IDX_W-1:0] mem_ra;
   logic [IDX_W-1:0] mem_rb;
   value_type        mem_qa;
   value_type        mem_qb;

   // shared compare
   value_type rank_a;
   value_type rank_b;
   logic      rank_above;

   logic             req_xfer;
   logic             rsp_free;
   logic [IDX_W-1:0] parent_idx;
   logic [IDX_W-1:0] base_idx;
   logic [CW1-1:0]   left_wide;
   logic [CW1-1:0]   right_wide;
   logic [CW1-1:0]   count_wide;
   logic             left_ok;
   logic             right_ok;

   bhpq_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_ra),
      .rd_addr_b (mem_rb),
      .rd_data_a (mem_qa),
      .rd_data_b (mem_qb)
   );

   bhpq_rank u_rank (
      .a_val     (rank_a),
      .b_val     (rank_b),
      .order_max (order_ff),
      .above     (rank_above)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // index arithmetic for the sifts
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;
   assign base_idx   = (state_ff == S_DN_CMP) ? child_ff : '0;
   assign left_wide  = (CW1'(base_idx) << 1) | CW1'(1);
   assign right_wide = left_wide + CW1'(1);
   assign count_wide = CW1'(count_ff);
   assign left_ok    = (left_wide < count_wide);
   assign right_ok   = (right_wide < count_wide);

   // operands of the shared compare unit
   always_comb begin
      rank_a = cur_ff;
      rank_b = mem_qa;
      if (state_ff == S_DN_SEL) begin
         rank_a = mem_qb;
      end else if (state_ff == S_DN_CMP) begin
         rank_a = child_val_ff;
         rank_b = cur_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      lidx_in      = lidx_ff;
      has_right_in = has_right_ff;
      child_in     = child_ff;
      child_val_in = child_val_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = cur_ff;
      mem_ra       = '0;
      mem_rb       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               popped_in = '0;
               status_in = ST_DONE;
               if (req_tuser == MODE_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_TOP_RD;
                  end else begin
                     pos_in   = IDX_W'(count_ff);
                     cur_in   = value_type'(req_tdata[VALUE_W-1:0]);
                     count_in = count_ff + CNT_W'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_TOP_RD;
                  end else begin
                     // root and last entry come back next cycle
                     mem_ra   = '0;
                     mem_rb   = IDX_W'(count_ff - CNT_W'(1));
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_POP_LD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = S_TOP_RD;
            end else begin
               mem_ra   = parent_idx;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_we = 1'b1;
            if (rank_above) begin
               // parent moves down into the hole
               mem_wdata = mem_qa;
               pos_in    = parent_idx;
               state_in  = S_UP_RD;
            end else begin
               state_in = S_TOP_RD;
            end
         end
         S_POP_LD: begin
            popped_in = mem_qa;
            cur_in    = mem_qb;
            pos_in    = '0;
            if (count_ff == '0) begin
               state_in = S_TOP_RD;
            end else if (left_ok) begin
               mem_ra       = left_wide[IDX_W-1:0];
               mem_rb       = right_wide[IDX_W-1:0];
               lidx_in      = left_wide[IDX_W-1:0];
               has_right_in = right_ok;
               state_in     = S_DN_SEL;
            end else begin
               state_in = S_PUT;
            end
         end
         S_DN_SEL: begin
            // on equal children the left one stays
            if (has_right_ff && rank_above) begin
               child_in     = lidx_ff + IDX_W'(1);
               child_val_in = mem_qb;
            end else begin
               child_in     = lidx_ff;
               child_val_in = mem_qa;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            if (rank_above) begin
               // child moves up, look at its children next
               mem_wdata = child_val_ff;
               pos_in    = child_ff;
               if (left_ok) begin
                  mem_ra       = left_wide[IDX_W-1:0];
                  mem_rb       = right_wide[IDX_W-1:0];
                  lidx_in      = left_wide[IDX_W-1:0];
                  has_right_in = right_ok;
                  state_in     = S_DN_SEL;
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               state_in = S_TOP_RD;
            end
         end
         S_PUT: begin
            mem_we   = 1'b1;
            state_in = S_TOP_RD;
         end
         S_TOP_RD: begin
            mem_ra   = '0;
            state_in = S_TOP_CAP;
         end
         S_TOP_CAP: begin
            mem_ra = '0;
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) begin
            order_ff <= csr_wdata;
         end
         if (state_ff == S_TOP_CAP && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      lidx_ff      <= lidx_in;
      has_right_ff <= has_right_in;
      child_ff     <= child_in;
      child_val_ff <= child_val_in;
      popped_ff    <= popped_in;
      status_ff    <= status_in;
      if (state_ff == S_TOP_CAP && rsp_free) begin
         rsp_popped_ff <= popped_ff;
         rsp_top_ff    <= (count_ff == '0) ? value_type'(0) : mem_qa;
         rsp_count_ff  <= ENTRY_COUNT_W'(count_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_count_ff, rsp_top_ff, rsp_popped_ff};
   assign rsp_tuser  = rsp_status_ff;

   // the fill count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("heap fill count above capacity");

   // a pop on an empty heap reports an empty heap
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_count_ff == '0))
      else $error("empty pop with nonzero count");

   // only a completed request reports a popped value
   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_DONE) |-> (rsp_popped_ff == '0))
      else $error("rejected request reports a popped value");

   // an accepted request keeps the sequencer busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("request accepted without sequencing");

endmodule

`default_nettype wire
